[design/iqd_pkg.sv]
// iqd_pkg: shared types and constants for the IQ packet deframer.
// Used by iqd_front, iqd_fifo, iqd_back and iq_packet_deframer.
// No dependencies.
package iqd_pkg;

  localparam int unsigned MAX_RECEIVERS = 8;
  localparam int unsigned RX_W          = 3;   // receiver index width
  localparam int unsigned NRX_W         = 4;   // receiver count register width
  localparam int unsigned POS_W         = 11;  // byte position counter width
  localparam int unsigned BASE_W        = 9;   // group base within an IQ area
  localparam int unsigned OFS_W         = 6;   // byte offset within a group

  localparam logic [POS_W-1:0]  PACKET_BYTES = 11'd1032;
  localparam logic [POS_W-1:0]  AREA1_START  = 11'd16;
  localparam logic [POS_W-1:0]  AREA1_END    = 11'd520;
  localparam logic [POS_W-1:0]  AREA2_START  = 11'd528;
  localparam logic [BASE_W:0]   AREA_BYTES   = 10'd504;
  localparam logic [NRX_W-1:0]  NRX_RESET    = 4'd1;
  localparam logic [NRX_W-1:0]  NRX_MAX      = 4'd8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam int unsigned OUT_DATA_W = 88;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_SHORT    = 2'd2,
    KIND_BAD_HDR  = 2'd3
  } kind_t;

  typedef enum logic {
    BK_FIRST  = 1'b0,
    BK_STATUS = 1'b1
  } back_state_t;

  // One queue entry: what one input byte produced.
  typedef struct packed {
    logic            smp_vld;
    logic [RX_W-1:0] rx;
    logic [23:0]     i_raw;
    logic [23:0]     q_raw;
    logic            sts_vld;
    kind_t           sts_kind;
  } iqd_entry_t;

  // Expected header bytes EF FE 01 06
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'hEF;
      2'd1:    v = 8'hFE;
      2'd2:    v = 8'h01;
      2'd3:    v = 8'h06;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[design/iqd_front.sv]
// iqd_front: takes payload bytes, tracks header, IQ areas and sample groups,
// and pushes one entry per byte that yields a sample and/or a status.
// Depends on iqd_pkg.
module iqd_front import iqd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tlast,
  input  logic                cfg_valid,
  input  logic [NRX_W-1:0]    cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output iqd_entry_t          q_entry
);

  logic [NRX_W-1:0]  nrx_r;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [BASE_W-1:0] base_r,   base_nxt;
  logic [OFS_W-1:0]  ofs_r,    ofs_nxt;
  logic [2:0]        within_r, within_nxt;
  logic [3:0]        rxc_r,    rxc_nxt;
  logic [39:0]       sb_r,     sb_nxt;

  logic              acc, in_win, in_area, area_first, fits, smp_byte, grp_end;
  logic [NRX_W-1:0]  nrx_eff;
  logic [OFS_W-1:0]  smp_len, gsize, ofs_cur;
  logic [BASE_W-1:0] base_cur;
  logic [2:0]        within_cur;
  logic [3:0]        rxc_cur;
  logic [POS_W-1:0]  pos_after;
  logic              emit_smp;
  kind_t             sts_kind;

  assign in_tready = ~q_full;
  assign acc       = in_tvalid & in_tready;

  assign in_win     = pos_r < PACKET_BYTES;
  assign in_area    = (pos_r >= AREA1_START && pos_r < AREA1_END) ||
                      (pos_r >= AREA2_START && pos_r < PACKET_BYTES);
  assign area_first = (pos_r == AREA1_START) || (pos_r == AREA2_START);

  assign nrx_eff  = (nrx_r > NRX_MAX) ? NRX_MAX : nrx_r;
  assign smp_len  = {{(OFS_W-NRX_W){1'b0}}, nrx_eff} * OFS_W'(6);
  assign gsize    = smp_len + OFS_W'(2);

  assign ofs_cur    = area_first ? '0 : ofs_r;
  assign base_cur   = area_first ? '0 : base_r;
  assign within_cur = area_first ? '0 : within_r;
  assign rxc_cur    = area_first ? '0 : rxc_r;

  assign fits     = ({1'b0, base_cur} + (BASE_W+1)'(gsize)) <= AREA_BYTES;
  assign smp_byte = ofs_cur < smp_len;
  // offset at or past the group end (register may have shrunk the group)
  assign grp_end  = ({1'b0, ofs_cur} + 7'd1) >= {1'b0, gsize};

  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    if (pos_r < POS_W'(4) && in_tdata != hdr_byte(pos_r[1:0])) begin
      hdr_ok_nxt = 1'b0;
    end
  end

  assign pos_after = in_win ? pos_r + POS_W'(1) : pos_r;
  assign emit_smp  = in_area && fits && smp_byte && within_cur == 3'd5 && hdr_ok_nxt;

  always_comb begin
    if (pos_after < PACKET_BYTES) begin
      sts_kind = KIND_SHORT;
    end else if (!hdr_ok_nxt) begin
      sts_kind = KIND_BAD_HDR;
    end else begin
      sts_kind = KIND_ACCEPTED;
    end
  end

  always_comb begin
    base_nxt   = base_r;
    ofs_nxt    = ofs_r;
    within_nxt = within_r;
    rxc_nxt    = rxc_r;
    sb_nxt     = sb_r;
    if (in_area) begin
      base_nxt   = base_cur;
      ofs_nxt    = ofs_cur;
      within_nxt = within_cur;
      rxc_nxt    = rxc_cur;
      if (fits) begin
        if (smp_byte) begin
          if (within_cur == 3'd0) begin
            sb_nxt = {32'd0, in_tdata};
          end else if (within_cur < 3'd5) begin
            sb_nxt = {sb_r[31:0], in_tdata};
          end else begin
            sb_nxt = '0;
          end
        end
        if (grp_end) begin
          base_nxt   = base_cur + BASE_W'(gsize);
          ofs_nxt    = '0;
          within_nxt = '0;
          rxc_nxt    = '0;
        end else begin
          ofs_nxt = ofs_cur + OFS_W'(1);
          if (within_cur == 3'd5) begin
            within_nxt = '0;
            rxc_nxt    = rxc_cur + 4'd1;
          end else begin
            within_nxt = within_cur + 3'd1;
          end
        end
      end
    end
  end

  assign q_push           = acc & (emit_smp | in_tlast);
  assign q_entry.smp_vld  = emit_smp;
  assign q_entry.rx       = rxc_cur[RX_W-1:0];
  assign q_entry.i_raw    = sb_r[39:16];
  assign q_entry.q_raw    = {sb_r[15:0], in_tdata};
  assign q_entry.sts_vld  = in_tlast;
  assign q_entry.sts_kind = sts_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrx_r <= NRX_RESET;
    end else if (cfg_valid) begin
      nrx_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b1;
      base_r   <= '0;
      ofs_r    <= '0;
      within_r <= '0;
      rxc_r    <= '0;
      sb_r     <= '0;
    end else if (acc) begin
      if (in_tlast) begin
        // rearm for the next datagram
        pos_r    <= '0;
        hdr_ok_r <= 1'b1;
        base_r   <= '0;
        ofs_r    <= '0;
        within_r <= '0;
        rxc_r    <= '0;
        sb_r     <= '0;
      end else if (in_win) begin
        pos_r    <= pos_after;
        hdr_ok_r <= hdr_ok_nxt;
        base_r   <= base_nxt;
        ofs_r    <= ofs_nxt;
        within_r <= within_nxt;
        rxc_r    <= rxc_nxt;
        sb_r     <= sb_nxt;
      end
    end
  end

endmodule

[design/iqd_fifo.sv]
// iqd_fifo: short register queue of deframer entries between front and back.
// Depends on iqd_pkg.
module iqd_fifo import iqd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  iqd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output iqd_entry_t head,
  output logic       empty
);

  iqd_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (FIFO_AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (FIFO_AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[design/iqd_back.sv]
// iqd_back: drains queue entries into result beats (sample, then status),
// keeps the accepted-packet count and holds the output register.
// Depends on iqd_pkg.
module iqd_back import iqd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iqd_entry_t            head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  back_state_t     st_r, st_nxt;
  logic            ov_r;
  kind_t           kind_r;
  logic [RX_W-1:0] rx_r;
  logic [23:0]     i_r;
  logic [24:0]     q_r;
  logic [31:0]     total_r;
  logic            last_r;
  logic [31:0]     cnt_r;
  logic            load, emit_smp;
  logic [31:0]     cnt_inc;

  assign load    = ~empty & (~ov_r | out_tready);
  assign cnt_inc = cnt_r + 32'd1;

  always_comb begin
    st_nxt = st_r;
    if (load) begin
      case (st_r)
        BK_FIRST:  st_nxt = (head.smp_vld && head.sts_vld) ? BK_STATUS : BK_FIRST;
        BK_STATUS: st_nxt = BK_FIRST;
        default:   st_nxt = BK_FIRST;
      endcase
    end
  end

  always_comb begin
    emit_smp = 1'b0;
    case (st_r)
      BK_FIRST:  emit_smp = head.smp_vld;
      BK_STATUS: emit_smp = 1'b0;
      default:   emit_smp = 1'b0;
    endcase
    pop = load & (~emit_smp | ~head.sts_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_FIRST;
      ov_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (load && !emit_smp && head.sts_kind == KIND_ACCEPTED) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_smp) begin
        kind_r  <= KIND_SAMPLE;
        rx_r    <= head.rx;
        i_r     <= head.i_raw;
        q_r     <= 25'd0 - {head.q_raw[23], head.q_raw};
        total_r <= '0;
        last_r  <= ~head.sts_vld;
      end else begin
        kind_r  <= head.sts_kind;
        rx_r    <= '0;
        i_r     <= '0;
        q_r     <= '0;
        total_r <= (head.sts_kind == KIND_ACCEPTED) ? cnt_inc : cnt_r;
        last_r  <= 1'b1;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'd0, total_r, q_r, i_r, rx_r};

endmodule

[design/iq_packet_deframer.sv]
// iq_packet_deframer: top level of the IQ packet deframer.
// Depends on iqd_pkg, iqd_front, iqd_fifo and iqd_back.
//
// Usage:
//   in_*  : one payload byte per beat, in_tlast on the final byte of a datagram.
//   out_* : result beats. out_tuser gives the kind (sample, accepted, short,
//           bad header); out_tlast marks the final result caused by one byte.
//   cfg_* : write of the receiver count; always ready, write only while idle.
// The front stage checks the EF FE 01 06 header and slices the two 504-byte
// IQ areas into per-receiver 24-bit I / negated Q samples; a four-entry queue
// feeds the back stage, which forms result beats and counts accepted packets.
// Throughput: one byte per cycle while the queue is not full. A byte gives
// at most one queue entry, and only the final byte of a datagram can give two
// result beats (sample, then status); entries pass the queue, then the output register.
// Reset clears the byte position, header flag, receiver count (to 1) and the
// packet count. When the receiver stalls, the output register holds its beat,
// the queue fills, and in_tready drops once four entries are waiting.
module iq_packet_deframer import iqd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_datagram
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] receiver, [26:3] i_sample,
                                            // [51:27] q_sample, [83:52] packet_total
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast,  // last_of_run
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [NRX_W-1:0]      cfg_data
);

  logic       q_full, q_push, q_pop, q_empty;
  iqd_entry_t q_entry, q_head;

  assign cfg_ready = 1'b1;

  iqd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  iqd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  iqd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/iq_packet_deframer_tb.sv]
// iq_packet_deframer_tb: self-checking testbench for the IQ packet deframer.
// A directed table, then random datagrams under several receiver counts; every
// result beat is checked against the table's expected status or an in-bench predictor. Depends on iqd_pkg.
`timescale 1ns / 100ps

module iq_packet_deframer_tb;
  import iqd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_PHASES   = 6;

  localparam logic [7:0] SYNC [4] = '{8'hEF, 8'hFE, 8'h01, 8'h06};

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  rx;
    logic [23:0] i_val;
    logic [24:0] q_val;
    logic [31:0] total;
    logic        run_end;
  } deframe_res_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eod;
    logic        typed;   // expected status written out below
    kind_t       kind;
    logic [31:0] total;
  } stim_row_t;

  // All directed datagrams are under 16 bytes, so only status beats come out.
  localparam int unsigned NUM_ROWS = 20;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{8'hFF, 1'b1, 1'b1, KIND_SHORT,  32'd0},  // one-byte datagram
    '{8'h00, 1'b1, 1'b1, KIND_SHORT,  32'd0},
    '{8'hEF, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},  // good header, then cut short
    '{8'hFE, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h01, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h06, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h00, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'hFF, 1'b1, 1'b1, KIND_SHORT,  32'd0},
    '{8'h10, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},  // bad and short: short wins
    '{8'hEF, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h01, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h06, 1'b1, 1'b1, KIND_SHORT,  32'd0},
    '{8'hEF, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},  // last sync byte off by one
    '{8'hFE, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h01, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h07, 1'b1, 1'b1, KIND_SHORT,  32'd0},
    '{8'h80, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h7F, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'h55, 1'b0, 1'b0, KIND_SAMPLE, 32'd0},
    '{8'hAA, 1'b1, 1'b1, KIND_SHORT,  32'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] data_byte
  logic                  in_tlast = 1'b0; // end_of_datagram
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [2:0] receiver, [26:3] i_sample,
                                          // [51:27] q_sample, [83:52] packet_total
  logic [1:0]            out_tuser;       // [1:0] kind
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NRX_W-1:0]      cfg_data = '0;

  // predictor state
  logic [NRX_W-1:0] rx_count;
  int unsigned      byte_pos;
  bit               hdr_ok;
  int unsigned      grp_base;
  int unsigned      grp_ofs;
  logic [39:0]      iq_bytes;
  logic [31:0]      accepted_cnt;

  deframe_res_t expected_beats[$];
  int unsigned  err_cnt = 0;
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b1;

  iq_packet_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // downstream stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void clear_datagram();
    byte_pos = 0;
    hdr_ok   = 1'b1;
    grp_base = 0;
    grp_ofs  = 0;
    iq_bytes = '0;
  endfunction

  // Advance the deframer state by one byte; n result beats land in res.
  function automatic void deframe_byte(input logic [7:0] b, input logic eod,
                                       output deframe_res_t res[2], output int n);
    int unsigned p, area_base, nrx, gsize, sub_ofs;
    bit          in_area;
    logic [23:0] q_raw;
    logic [24:0] q_neg;
    kind_t       k;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (byte_pos < PACKET_BYTES) begin
      p = byte_pos;
      if (p < 4 && b != SYNC[p]) hdr_ok = 1'b0;
      in_area = 1'b0;
      area_base = 0;
      if (p >= AREA1_START && p < AREA1_END) begin
        in_area = 1'b1;
        area_base = AREA1_START;
      end else if (p >= AREA2_START && p < AREA2_START + AREA_BYTES) begin
        in_area = 1'b1;
        area_base = AREA2_START;
      end
      if (in_area) begin
        nrx = (rx_count > NRX_MAX) ? NRX_MAX : rx_count;
        gsize = nrx * 6 + 2;
        if (p == area_base) begin
          grp_base = 0;
          grp_ofs  = 0;
        end
        // partial group at the end of an area is skipped
        if (grp_base + gsize <= AREA_BYTES) begin
          if (grp_ofs < nrx * 6) begin
            sub_ofs = grp_ofs % 6;
            if (sub_ofs == 0) begin
              iq_bytes = {32'd0, b};
            end else if (sub_ofs < 5) begin
              iq_bytes = {iq_bytes[31:0], b};
            end else begin
              q_raw = {iq_bytes[15:0], b};
              q_neg = -{q_raw[23], q_raw};
              if (hdr_ok) begin
                res[n].kind    = KIND_SAMPLE;
                res[n].rx      = 3'(grp_ofs / 6);
                res[n].i_val   = iq_bytes[39:16];
                res[n].q_val   = q_neg;
                res[n].total   = '0;
                res[n].run_end = 1'b0;
                n++;
              end
              iq_bytes = '0;
            end
          end
          // mic bytes fall through here; an offset past a shrunk group closes it
          if (grp_ofs + 1 >= gsize) begin
            grp_base += gsize;
            grp_ofs = 0;
          end else begin
            grp_ofs++;
          end
        end
      end
      byte_pos = p + 1;
    end
    if (eod) begin
      if (byte_pos < PACKET_BYTES) begin
        k = KIND_SHORT;
      end else if (!hdr_ok) begin
        k = KIND_BAD_HDR;
      end else begin
        k = KIND_ACCEPTED;
        accepted_cnt++;
      end
      res[n].kind    = k;
      res[n].rx      = '0;
      res[n].i_val   = '0;
      res[n].q_val   = '0;
      res[n].total   = accepted_cnt;
      res[n].run_end = 1'b0;
      n++;
      clear_datagram();
    end
    if (n > 0) res[n-1].run_end = 1'b1;
  endfunction

  task automatic log_error(input string why, input deframe_res_t got,
                           input deframe_res_t want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display({"%s at %0t: got kind=%0d rx=%0d i=%06h q=%07h total=%0d last=%0b",
                " | want kind=%0d rx=%0d i=%06h q=%07h total=%0d last=%0b"},
               why, $realtime, got.kind, got.rx, got.i_val, got.q_val, got.total,
               got.run_end, want.kind, want.rx, want.i_val, want.q_val, want.total,
               want.run_end);
  endtask

  always @(posedge clk) begin : beat_check
    deframe_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind    = kind_t'(out_tuser);
      got.rx      = out_tdata[2:0];
      got.i_val   = out_tdata[26:3];
      got.q_val   = out_tdata[51:27];
      got.total   = out_tdata[83:52];
      got.run_end = out_tlast;
      if (expected_beats.size() == 0) begin
        log_error("unexpected beat", got, '0);
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.rx !== want.rx || got.i_val !== want.i_val ||
            got.q_val !== want.q_val || got.total !== want.total ||
            got.run_end !== want.run_end)
          log_error("beat mismatch", got, want);
      end
    end
  end

  // Present one byte, wait for the handshake, then book its expected beats.
  task automatic push_byte(input logic [7:0] b, input logic eod, input logic typed,
                           input kind_t kind, input logic [31:0] total);
    deframe_res_t res[2];
    deframe_res_t row_res;
    int           n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b, eod, res, n);
    if (typed) begin
      row_res = '0;
      row_res.kind    = kind;
      row_res.total   = total;
      row_res.run_end = 1'b1;
      expected_beats.push_back(row_res);
    end else begin
      for (int j = 0; j < n; j++) expected_beats.push_back(res[j]);
    end
  endtask

  // Only written with the pipe drained.
  task automatic write_nrx(input logic [NRX_W-1:0] v);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rx_count = v;
  endtask

  // lean toward full-scale and mid-scale sample bytes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_datagram(input int len, input bit bad_hdr, input bit noise,
                               input int cfg_at);
    int         bad_at;
    logic [7:0] b;
    bad_at = bad_hdr ? int'($urandom_range(0, 3)) : -1;
    for (int i = 0; i < len; i++) begin
      if (noise) b = 8'($urandom);
      else if (i < 4) b = (i == bad_at) ? SYNC[i] ^ 8'($urandom_range(1, 255)) : SYNC[i];
      else b = payload_byte();
      push_byte(b, i == len - 1, 1'b0, KIND_SAMPLE, 32'd0);
      if (i == cfg_at) write_nrx(NRX_W'($urandom_range(1, 15)));
    end
  endtask

  initial begin : stimulus
    logic [NRX_W-1:0] nrx;
    int               dg_len;
    rx_count     = NRX_RESET;
    accepted_cnt = '0;
    clear_datagram();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      push_byte(DIR_ROWS[r].data, DIR_ROWS[r].eod, DIR_ROWS[r].typed,
                DIR_ROWS[r].kind, DIR_ROWS[r].total);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       nrx = 4'd8;
        1:       nrx = 4'd0;   // two-byte groups, no samples
        2:       nrx = 4'd15;  // clamps to eight receivers
        3:       nrx = 4'd3;
        4:       nrx = 4'd1;
        default: nrx = NRX_W'($urandom_range(2, 7));
      endcase
      write_nrx(nrx);
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      send_datagram($urandom_range(1, 40), 1'b0, 1'b1, -1);
      if (ph == 4) begin
        // full packet; trailing bytes past the packet length are ignored but
        // still carry the end flag
        dg_len = int'(PACKET_BYTES) + int'($urandom_range(0, 8));
        send_datagram(dg_len, 1'b0, 1'b0, -1);
      end else begin
        dg_len = int'($urandom_range(17, 130));
        send_datagram(dg_len, $urandom_range(0, 3) == 0, 1'b0,
                      (ph == 3) ? int'($urandom_range(17, dg_len - 2)) : -1);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/iqd_pkg.sv
design/iqd_front.sv
design/iqd_fifo.sv
design/iqd_back.sv
design/iq_packet_deframer.sv
tb/iq_packet_deframer_tb.sv
